// File: rtl/hus_pkg.sv
package hus_pkg;

  typedef enum logic [2:0] {
    PH_PFX_HTTP,
    PH_PFX_HTTPS,
    PH_HOST,
    PH_PORT,
    PH_PATH,
    PH_FRAG
  } hus_phase_t;

  localparam logic [1:0] ROLE_DROP = 2'd0;
  localparam logic [1:0] ROLE_HOST = 2'd1;
  localparam logic [1:0] ROLE_PATH = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HTTPS     = 3'd1;
  localparam logic [2:0] ST_NOT_HTTP  = 3'd2;
  localparam logic [2:0] ST_HOST_BAD  = 3'd3;
  localparam logic [2:0] ST_PORT_BAD  = 3'd4;
  localparam logic [2:0] ST_URL_BAD   = 3'd5;
  localparam logic [2:0] ST_PATH_LONG = 3'd6;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_LIMIT = 1'b1;

  localparam logic [7:0] HOST_LIMIT_RST = 8'd63;
  localparam logic [7:0] PATH_LIMIT_RST = 8'd95;

  localparam logic [15:0] PORT_DEFAULT   = 16'd80;
  localparam logic [15:0] PORT_GUARD     = 16'd6553;
  localparam logic [3:0]  PORT_DIGIT_MAX = 4'd5;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [3:0] PFX_S_POS    = 4'd4;
  localparam logic [3:0] PFX_HTTP_LEN = 4'd7;
  localparam logic [3:0] PFX_TLS_LO   = 4'd5;
  localparam logic [3:0] PFX_TLS_END  = 4'd8;

  typedef struct packed {
    hus_phase_t  phase;
    logic [3:0]  prefix_pos;
    logic [15:0] port_acc;
    logic        port_seen_digit;
    logic [2:0]  error_code;
    logic [7:0]  host_count;
    logic [7:0]  path_count;
  } hus_state_t;

  typedef struct packed {
    logic [1:0]  role;
    logic [7:0]  out_byte;
    logic        slash_before;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] port_out;
    logic [7:0]  host_len;
    logic [7:0]  path_len;
  } hus_result_t;

  localparam hus_state_t STATE_RST = '{
    phase:           PH_PFX_HTTP,
    prefix_pos:      4'd0,
    port_acc:        16'd0,
    port_seen_digit: 1'b0,
    error_code:      ST_OK,
    host_count:      8'd0,
    path_count:      8'd0
  };

  function automatic logic [7:0] http_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0: c = 8'h68;
      4'd1: c = 8'h74;
      4'd2: c = 8'h74;
      4'd3: c = 8'h70;
      4'd4: c = CH_COLON;
      4'd5: c = CH_SLASH;
      4'd6: c = CH_SLASH;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tls_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd5: c = CH_COLON;
      4'd6: c = CH_SLASH;
      4'd7: c = CH_SLASH;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFS;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

// File: rtl/hus_step.sv
module hus_step import hus_pkg::*; (
  input  hus_state_t  cur,
  input  logic [7:0]  in_char,
  input  logic        is_end,
  input  logic [7:0]  host_limit,
  input  logic [7:0]  path_limit,
  output hus_state_t  nxt,
  output hus_result_t res
);

  logic        ent_ok;
  logic [1:0]  ent_role;
  logic        ent_slash;
  logic [7:0]  ent_count;
  hus_phase_t  ent_phase;
  logic [7:0]  lc;
  logic [3:0]  digit;
  logic [15:0] acc_x10;
  logic        is_digit;
  logic        is_delim;
  hus_state_t  upd;

  assign lc       = to_lower(in_char);
  assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign digit    = 4'(in_char - CH_ZERO);
  assign acc_x10  = {cur.port_acc[14:0], 1'b0} + {cur.port_acc[12:0], 3'b000};
  assign is_delim = (in_char == CH_SLASH) || (in_char == CH_COLON) ||
                    (in_char == CH_QUEST) || (in_char == CH_HASH);

  // start of path at '/' or '?', or of the fragment at '#'
  always_comb begin
    if (in_char == CH_SLASH) begin
      ent_ok    = (path_limit != 8'd0);
      ent_role  = ROLE_PATH;
      ent_slash = 1'b0;
      ent_count = 8'd1;
      ent_phase = PH_PATH;
    end else if (in_char == CH_QUEST) begin
      ent_ok    = (path_limit > 8'd1);
      ent_role  = ROLE_PATH;
      ent_slash = 1'b1;
      ent_count = 8'd2;
      ent_phase = PH_PATH;
    end else begin
      ent_ok    = 1'b1;
      ent_role  = ROLE_DROP;
      ent_slash = 1'b1;
      ent_count = 8'd1;
      ent_phase = PH_FRAG;
    end
  end

  always_comb begin
    upd = cur;
    res = '0;
    if (is_end) begin
      res.done_res = 1'b1;
      if (cur.error_code == ST_OK) begin
        unique case (cur.phase)
          PH_PFX_HTTP, PH_PFX_HTTPS: begin
            upd.error_code = ST_NOT_HTTP;
          end
          PH_HOST: begin
            if (cur.host_count == 8'd0) begin
              upd.error_code = ST_HOST_BAD;
            end else begin
              upd.port_acc     = PORT_DEFAULT;
              res.slash_before = 1'b1;
              upd.path_count   = 8'd1;
            end
          end
          PH_PORT: begin
            if (!cur.port_seen_digit || cur.port_acc == 16'd0) begin
              upd.error_code = ST_PORT_BAD;
            end else begin
              res.slash_before = 1'b1;
              upd.path_count   = 8'd1;
            end
          end
          PH_PATH, PH_FRAG: begin
          end
          default: begin
          end
        endcase
      end
      res.status   = upd.error_code;
      res.port_out = (upd.error_code == ST_OK) ? upd.port_acc : 16'd0;
    end else if (cur.error_code == ST_OK) begin
      unique case (cur.phase)
        PH_PFX_HTTP: begin
          if (cur.prefix_pos == PFX_S_POS && lc == CH_S) begin
            upd.phase      = PH_PFX_HTTPS;
            upd.prefix_pos = PFX_TLS_LO;
          end else if (cur.prefix_pos < PFX_HTTP_LEN && lc == http_char(cur.prefix_pos)) begin
            upd.prefix_pos = cur.prefix_pos + 4'd1;
            if (cur.prefix_pos + 4'd1 == PFX_HTTP_LEN) begin
              upd.phase = PH_HOST;
            end
          end else begin
            upd.error_code = ST_NOT_HTTP;
          end
        end
        PH_PFX_HTTPS: begin
          if (cur.prefix_pos >= PFX_TLS_LO && cur.prefix_pos < PFX_TLS_END &&
              lc == tls_char(cur.prefix_pos)) begin
            upd.prefix_pos = cur.prefix_pos + 4'd1;
            if (cur.prefix_pos + 4'd1 == PFX_TLS_END) begin
              upd.error_code = ST_HTTPS;
            end
          end else begin
            upd.error_code = ST_NOT_HTTP;
          end
        end
        PH_HOST: begin
          if (is_delim) begin
            if (cur.host_count == 8'd0) begin
              upd.error_code = ST_HOST_BAD;
            end else if (in_char == CH_COLON) begin
              upd.phase           = PH_PORT;
              upd.port_acc        = 16'd0;
              upd.port_seen_digit = 1'b0;
            end else begin
              upd.port_acc = PORT_DEFAULT;
              if (ent_ok) begin
                res.role         = ent_role;
                res.out_byte     = (ent_role == ROLE_DROP) ? 8'd0 : in_char;
                res.slash_before = ent_slash;
                upd.path_count   = ent_count;
                upd.phase        = ent_phase;
              end else begin
                upd.error_code = ST_PATH_LONG;
              end
            end
          end else if (cur.host_count < host_limit) begin
            res.role       = ROLE_HOST;
            res.out_byte   = in_char;
            upd.host_count = cur.host_count + 8'd1;
          end else begin
            upd.error_code = ST_HOST_BAD;
          end
        end
        PH_PORT: begin
          if (is_digit) begin
            if (cur.port_acc > PORT_GUARD ||
                (cur.port_acc == PORT_GUARD && digit > PORT_DIGIT_MAX)) begin
              upd.error_code = ST_PORT_BAD;
            end else begin
              upd.port_acc        = acc_x10 + {12'd0, digit};
              upd.port_seen_digit = 1'b1;
            end
          end else if (!cur.port_seen_digit || cur.port_acc == 16'd0) begin
            upd.error_code = ST_PORT_BAD;
          end else if (in_char == CH_SLASH || in_char == CH_QUEST || in_char == CH_HASH) begin
            if (ent_ok) begin
              res.role         = ent_role;
              res.out_byte     = (ent_role == ROLE_DROP) ? 8'd0 : in_char;
              res.slash_before = ent_slash;
              upd.path_count   = ent_count;
              upd.phase        = ent_phase;
            end else begin
              upd.error_code = ST_PATH_LONG;
            end
          end else begin
            upd.error_code = ST_URL_BAD;
          end
        end
        PH_PATH: begin
          if (in_char == CH_HASH) begin
            upd.phase = PH_FRAG;
          end else if (cur.path_count < path_limit) begin
            res.role       = ROLE_PATH;
            res.out_byte   = in_char;
            upd.path_count = cur.path_count + 8'd1;
          end else begin
            upd.error_code = ST_PATH_LONG;
          end
        end
        PH_FRAG: begin
        end
        default: begin
        end
      endcase
    end
    res.host_len = upd.host_count;
    res.path_len = upd.path_count;
    nxt = is_end ? STATE_RST : upd;
  end

endmodule

// File: rtl/http_url_splitter.sv
// each character passes the input register, then the result register
// throughput: one character per cycle unless stalled; url_state closes the only loop
// input stalls only while the input register is full and the held result is stalled
// reset: synchronous active-high rst clears the url state and both valid flags,
// and loads host_limit 63 and path_limit 95
module http_url_splitter import hus_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char,
  input  logic                 is_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           role,
  output logic [7:0]           out_byte,
  output logic                 slash_before,
  output logic                 done_res,
  output logic [2:0]           status,
  output logic [15:0]          port_out,
  output logic [7:0]           host_len,
  output logic [7:0]           path_len,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic        s0_valid;
  logic [7:0]  s0_char;
  logic        s0_end;
  logic        out_adv;
  logic [7:0]  host_limit;
  logic [7:0]  path_limit;
  hus_state_t  url_state;
  hus_state_t  url_state_next;
  hus_result_t step_res;
  hus_result_t out_res;

  assign out_adv   = !out_valid || !out_stall;
  assign in_stall  = s0_valid && !out_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_limit <= HOST_LIMIT_RST;
      path_limit <= PATH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOST_LIMIT: host_limit <= cfg_data;
        CFG_PATH_LIMIT: path_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!in_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_char <= in_char;
      s0_end  <= is_end;
    end
  end

  hus_step u_step (
    .cur        (url_state),
    .in_char    (s0_char),
    .is_end     (s0_end),
    .host_limit (host_limit),
    .path_limit (path_limit),
    .nxt        (url_state_next),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      url_state <= STATE_RST;
    end else if (s0_valid && out_adv) begin
      url_state <= url_state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && out_adv) begin
      out_res <= step_res;
    end
  end

  assign role         = out_res.role;
  assign out_byte     = out_res.out_byte;
  assign slash_before = out_res.slash_before;
  assign done_res     = out_res.done_res;
  assign status       = out_res.status;
  assign port_out     = out_res.port_out;
  assign host_len     = out_res.host_len;
  assign path_len     = out_res.path_len;

endmodule

// File: rtl/hus_checker.sv
module hus_checker import hus_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  role,
  input logic [7:0]  out_byte,
  input logic        slash_before,
  input logic        done_res,
  input logic [2:0]  status,
  input logic [15:0] port_out,
  input logic [7:0]  host_len,
  input logic [7:0]  path_len
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(role) && $stable(out_byte) &&
    $stable(slash_before) && $stable(done_res) && $stable(status) &&
    $stable(port_out) && $stable(host_len) && $stable(path_len))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_mid_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == ST_OK && port_out == 16'd0)
    else $error("status or port on a non-end result");

  a_err_no_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && status != ST_OK |-> port_out == 16'd0 && role == ROLE_DROP)
    else $error("port or byte on a failed end result");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && role == ROLE_DROP |-> out_byte == 8'd0)
    else $error("dropped byte carries data");

endmodule

bind http_url_splitter hus_checker u_hus_checker (.*);
